// ----- rtl/sha1_pkg.sv -----
`timescale 1ns / 1ps

package sha1_pkg;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_word;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [6:0] LAST_RND  = 7'd79;
    localparam logic [2:0] LAST_WORD = 3'd4;

endpackage

// ----- rtl/sha1_hash_engine_unit.sv -----
`timescale 1ns / 1ps
// Append word: accepted while idle; the 64th byte of a block starts 80 rounds
// on the one shared round adder, then the chaining add.
// Finish word: padding bytes go in at one per cycle, each padded block is hashed,
// then five digest words, one per cycle when not stalled.
// Input stalls during hashing, so the single round unit sets the sustained rate.
// Synchronous active-low reset loads the initial chaining values and clears length.
module sha1_hash_engine_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sha1_pkg::t_in_word  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sha1_pkg::t_out_word o_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    t_state       r_state, n_state;
    logic [511:0] r_blk, n_blk;
    logic [31:0]  r_h [5];
    logic [31:0]  n_h [5];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [31:0]  n_a, n_b, n_c, n_d, n_e;
    logic [5:0]   r_pos, n_pos;
    logic [63:0]  r_len, n_len;
    logic [6:0]   r_rnd, n_rnd;
    logic [2:0]   r_oidx, n_oidx;
    logic         r_fin, n_fin;
    logic         r_lphase, n_lphase;

    logic         push_en;
    logic [7:0]   push_byte;
    logic [7:0]   len_byte;
    logic [31:0]  w_new, f_val, k_val, t_val;

    assign len_byte = r_len[{~r_pos[2:0], 3'b000} +: 8];
    assign w_new = {r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ r_blk[511:480]}
                   << 1 | {31'd0, r_blk[95] ^ r_blk[255] ^ r_blk[447] ^ r_blk[511]};

    always_comb begin
        if (r_rnd < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = sha1_pkg::K0;
        end else if (r_rnd < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1_pkg::K1;
        end else if (r_rnd < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = sha1_pkg::K2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1_pkg::K3;
        end
        t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + r_blk[511:480];
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);

    always_comb begin
        o_out.digest_word = r_h[0];
        case (r_oidx)
            3'd0:    o_out.digest_word = r_h[0];
            3'd1:    o_out.digest_word = r_h[1];
            3'd2:    o_out.digest_word = r_h[2];
            3'd3:    o_out.digest_word = r_h[3];
            default: o_out.digest_word = r_h[4];
        endcase
        o_out.word_index = r_oidx;
        o_out.last_word  = (r_oidx == sha1_pkg::LAST_WORD);
    end

    always_comb begin
        n_state  = r_state;
        n_blk    = r_blk;
        n_h      = r_h;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_d      = r_d;
        n_e      = r_e;
        n_pos    = r_pos;
        n_len    = r_len;
        n_rnd    = r_rnd;
        n_oidx   = r_oidx;
        n_fin    = r_fin;
        n_lphase = r_lphase;
        push_en   = 1'b0;
        push_byte = 8'd0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    push_en = 1'b1;
                    if (i_in.req_type) begin
                        push_byte = sha1_pkg::PAD_BYTE;
                        n_fin     = 1'b1;
                    end else begin
                        push_byte = i_in.data_byte;
                        n_len     = r_len + 64'd8;
                    end
                end
            end
            ST_PAD: begin
                push_en = 1'b1;
                if (r_lphase || r_pos == sha1_pkg::LEN_POS) begin
                    push_byte = len_byte;
                    n_lphase  = 1'b1;
                end
            end
            ST_ROUND: begin
                n_blk = {r_blk[479:0], w_new};
                n_e   = r_d;
                n_d   = r_c;
                n_c   = {r_b[1:0], r_b[31:2]};
                n_b   = r_a;
                n_a   = t_val;
                n_rnd = r_rnd + 7'd1;
                if (r_rnd == sha1_pkg::LAST_RND) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_h[0] = r_h[0] + r_a;
                n_h[1] = r_h[1] + r_b;
                n_h[2] = r_h[2] + r_c;
                n_h[3] = r_h[3] + r_d;
                n_h[4] = r_h[4] + r_e;
                if (r_fin && r_lphase) begin
                    n_state = ST_OUT;
                    n_oidx  = 3'd0;
                end else if (r_fin) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    if (r_oidx == sha1_pkg::LAST_WORD) begin
                        n_state  = ST_IDLE;
                        n_h[0]   = sha1_pkg::H0_INIT;
                        n_h[1]   = sha1_pkg::H1_INIT;
                        n_h[2]   = sha1_pkg::H2_INIT;
                        n_h[3]   = sha1_pkg::H3_INIT;
                        n_h[4]   = sha1_pkg::H4_INIT;
                        n_len    = 64'd0;
                        n_fin    = 1'b0;
                        n_lphase = 1'b0;
                        n_oidx   = 3'd0;
                    end else begin
                        n_oidx = r_oidx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (push_en) begin
            n_blk = {r_blk[503:0], push_byte};
            n_pos = r_pos + 6'd1;
            if (r_pos == sha1_pkg::LAST_POS) begin
                n_state = ST_ROUND;
                n_rnd   = 7'd0;
                n_a     = r_h[0];
                n_b     = r_h[1];
                n_c     = r_h[2];
                n_d     = r_h[3];
                n_e     = r_h[4];
            end else if (n_fin) begin
                n_state = ST_PAD;
            end else begin
                n_state = ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_h[0]   <= sha1_pkg::H0_INIT;
            r_h[1]   <= sha1_pkg::H1_INIT;
            r_h[2]   <= sha1_pkg::H2_INIT;
            r_h[3]   <= sha1_pkg::H3_INIT;
            r_h[4]   <= sha1_pkg::H4_INIT;
            r_pos    <= 6'd0;
            r_len    <= 64'd0;
            r_rnd    <= 7'd0;
            r_oidx   <= 3'd0;
            r_fin    <= 1'b0;
            r_lphase <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_h      <= n_h;
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_rnd    <= n_rnd;
            r_oidx   <= n_oidx;
            r_fin    <= n_fin;
            r_lphase <= n_lphase;
        end
        r_blk <= n_blk;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        r_e   <= n_e;
    end

endmodule
